FILE: rtl/gdbd_pkg.sv
// Shared widths, codes, calendar tables and constant-divide helpers for the day counter.
`default_nettype none
package gdbd_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int YCMP_W  = 17;
	localparam int DN_W    = 23;
	localparam int YDAY_W  = 9;
	localparam int Q100_W  = 8;
	localparam int CNT_W   = 22;
	localparam int AGEY_W  = 14;
	localparam int AGEM_W  = 4;
	localparam int AGED_W  = 5;
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          SHIFT_100  = 19;
	localparam logic [22:0] RECIP_365  = 23'd5883517;
	localparam int          SHIFT_365  = 31;
	localparam logic [9:0]  RECIP_30   = 10'd547;
	localparam int          SHIFT_30   = 14;

	localparam int unsigned MONTH_FEB = 2;
	localparam int unsigned MONTH_DEC = 12;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_ORDER   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [YDAY_W-1:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:    r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] x);
		logic [YEAR_W+12:0] p;
		p = {13'd0, x} * {{YEAR_W{1'b0}}, RECIP_100};
		return p[SHIFT_100 +: Q100_W];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/gdbd_date.sv
// Three-stage date unit: validity check, leap year and day number since 1 January of year 1.
`default_nettype none
module gdbd_date import gdbd_pkg::*; #(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [DAY_W-1:0]   day,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [YEAR_W-1:0]  year,
	output logic                    ok,
	output logic [DN_W-1:0]         day_num
);

	logic [DAY_W-1:0]   d_s1;
	logic [MONTH_W-1:0] m_s1;
	logic [YEAR_W-1:0]  y_s1;
	logic [YEAR_W-1:0]  a_s1;
	logic [Q100_W-1:0]  qa100_s1;
	logic [Q100_W-1:0]  qa400_s1;
	logic [Q100_W-1:0]  qy100_s1;

	logic               ok_s2;
	logic [YDAY_W-1:0]  yday_s2;
	logic [DN_W-1:0]    ybase_s2;

	logic               ok_s3;
	logic [DN_W-1:0]    dn_s3;

	logic [YEAR_W-1:0]  a_in;
	logic [YEAR_W-1:0]  ry;
	logic               leap;
	logic [DAY_W-1:0]   len;
	logic               valid_date;
	logic [YDAY_W-1:0]  yday;
	logic [DN_W-1:0]    ybase;

	assign a_in = year - 14'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1     <= day;
			m_s1     <= month;
			y_s1     <= year;
			a_s1     <= a_in;
			qa100_s1 <= div100(a_in);
			qa400_s1 <= div100({2'b00, a_in[YEAR_W-1:2]});
			qy100_s1 <= div100(year);
		end
	end

	always_comb begin
		ry   = y_s1 - YEAR_W'({6'd0, qy100_s1} * 14'd100);
		leap = ((y_s1[1:0] == 2'b00) && (ry != '0)) ||
			((ry == '0) && (qy100_s1[1:0] == 2'b00));
		len  = month_len(m_s1, leap);
		valid_date = (y_s1 != '0) &&
			({{(YCMP_W-YEAR_W){1'b0}}, y_s1} <= YCMP_W'(MAX_YEAR)) &&
			(m_s1 >= 4'd1) && (m_s1 <= MONTH_W'(MONTH_DEC)) &&
			(d_s1 >= 5'd1) && (d_s1 <= len);
		yday = days_before(m_s1) + YDAY_W'(d_s1 - 5'd1) +
			YDAY_W'((m_s1 > MONTH_W'(MONTH_FEB)) && leap);
		ybase = DN_W'({9'd0, a_s1} * 23'd365) + DN_W'(a_s1[YEAR_W-1:2]) -
			DN_W'(qa100_s1) + DN_W'(qa400_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2    <= valid_date;
			yday_s2  <= yday;
			ybase_s2 <= ybase;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3 <= ok_s2;
			dn_s3 <= ybase_s2 + DN_W'(yday_s2);
		end
	end

	assign ok      = ok_s3;
	assign day_num = dn_s3;

endmodule
`default_nettype wire

FILE: rtl/gdbd_age.sv
// Five-stage split of the day count into years, months and days by constant reciprocals.
`default_nettype none
module gdbd_age import gdbd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DN_W-1:0]   diff,
	input  wire status_t           stat_in,
	output logic [CNT_W-1:0]       day_count,
	output logic [AGEY_W-1:0]      age_years,
	output logic [AGEM_W-1:0]      age_months,
	output logic [AGED_W-1:0]      age_days,
	output status_t                stat_out
);

	logic [CNT_W-1:0]  cnt_s5, cnt_s6, cnt_s7, cnt_s8, cnt_s9;
	status_t           st_s5, st_s6, st_s7, st_s8, st_s9;
	logic [AGEY_W-1:0] yr_s6, yr_s7, yr_s8, yr_s9;
	logic [YDAY_W-1:0] rem_s7, rem_s8;
	logic [AGEM_W-1:0] mo_s8, mo_s9;
	logic [AGED_W-1:0] dy_s9;

	logic [CNT_W+22:0]   prod365;
	logic [YDAY_W+9:0]   prod30;

	assign prod365 = {23'd0, cnt_s5} * {{CNT_W{1'b0}}, RECIP_365};
	assign prod30  = {10'd0, rem_s7} * {{YDAY_W{1'b0}}, RECIP_30};

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s5 <= diff[DN_W-1] ? COUNT_MAX : diff[CNT_W-1:0];
			st_s5  <= stat_in;

			cnt_s6 <= cnt_s5;
			st_s6  <= st_s5;
			yr_s6  <= prod365[SHIFT_365 +: AGEY_W];

			cnt_s7 <= cnt_s6;
			st_s7  <= st_s6;
			yr_s7  <= yr_s6;
			rem_s7 <= YDAY_W'(cnt_s6 - CNT_W'({8'd0, yr_s6} * 22'd365));

			cnt_s8 <= cnt_s7;
			st_s8  <= st_s7;
			yr_s8  <= yr_s7;
			rem_s8 <= rem_s7;
			mo_s8  <= prod30[SHIFT_30 +: AGEM_W];

			cnt_s9 <= cnt_s8;
			st_s9  <= st_s8;
			yr_s9  <= yr_s8;
			mo_s9  <= mo_s8;
			dy_s9  <= AGED_W'(rem_s8 - YDAY_W'({5'd0, mo_s8} * 9'd30));
		end
	end

	assign day_count  = cnt_s9;
	assign age_years  = yr_s9;
	assign age_months = mo_s9;
	assign age_days   = dy_s9;
	assign stat_out   = st_s9;

endmodule
`default_nettype wire

FILE: rtl/gregorian_days_between_dates_core.sv
// Top level: Gregorian days between two dates with rough age split, nine-stage pipeline.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------------------------------------
//  input   | in_valid  | in_ready  | start_day/month/year, end_day/month/year
//  output  | out_valid | out_ready | day_count, age_years, age_months, age_days, status
//
//  Nine register stages: three in each date unit, one for compare and subtract,
//  five in the age split, the last of which drives out_valid. One transfer per cycle
//  is taken unless the output stalls; the depth is set by the constant multiplies.
//  Reset clears the stage valid bits only; no clearing pass is needed.
//  When the last stage holds a result that is not taken, the whole pipeline holds.
`default_nettype none
module gregorian_days_between_dates_core import gdbd_pkg::*; #(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [DAY_W-1:0]   start_day,
	input  wire logic [MONTH_W-1:0] start_month,
	input  wire logic [YEAR_W-1:0]  start_year,
	input  wire logic [DAY_W-1:0]   end_day,
	input  wire logic [MONTH_W-1:0] end_month,
	input  wire logic [YEAR_W-1:0]  end_year,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [CNT_W-1:0]        day_count,
	output logic [AGEY_W-1:0]       age_years,
	output logic [AGEM_W-1:0]       age_months,
	output logic [AGED_W-1:0]       age_days,
	output logic [STAT_W-1:0]       status
);

	localparam int NSTAGE = 9;

	logic [NSTAGE-1:0] vld_q;
	logic              en;

	logic              ok_a, ok_b;
	logic [DN_W-1:0]   dn_a, dn_b;

	logic [DN_W-1:0]   diff_s4;
	status_t           st_s4;
	status_t           st_out;

	assign en       = !vld_q[NSTAGE-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	gdbd_date #(.MAX_YEAR(MAX_YEAR)) u_date_start (
		.clk     (clk),
		.en      (en),
		.day     (start_day),
		.month   (start_month),
		.year    (start_year),
		.ok      (ok_a),
		.day_num (dn_a)
	);

	gdbd_date #(.MAX_YEAR(MAX_YEAR)) u_date_end (
		.clk     (clk),
		.en      (en),
		.day     (end_day),
		.month   (end_month),
		.year    (end_year),
		.ok      (ok_b),
		.day_num (dn_b)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!(ok_a && ok_b)) begin
				st_s4   <= STATUS_INVALID;
				diff_s4 <= '0;
			end else if (dn_b < dn_a) begin
				st_s4   <= STATUS_ORDER;
				diff_s4 <= '0;
			end else begin
				st_s4   <= STATUS_OK;
				diff_s4 <= dn_b - dn_a;
			end
		end
	end

	gdbd_age u_age (
		.clk        (clk),
		.en         (en),
		.diff       (diff_s4),
		.stat_in    (st_s4),
		.day_count  (day_count),
		.age_years  (age_years),
		.age_months (age_months),
		.age_days   (age_days),
		.stat_out   (st_out)
	);

	assign status    = st_out;
	assign out_valid = vld_q[NSTAGE-1];

endmodule
`default_nettype wire

FILE: tb/sv/day_span_checker.sv
// Checker for the day counter: predicts each result from the input transfers and compares.
`timescale 1ns / 1ps
module day_span_checker import gdbd_pkg::*; #(
	parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [DAY_W-1:0]   end_day,
	input  logic [MONTH_W-1:0] end_month,
	input  logic [YEAR_W-1:0]  end_year,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [CNT_W-1:0]   day_count,
	input  logic [AGEY_W-1:0]  age_years,
	input  logic [AGEM_W-1:0]  age_months,
	input  logic [AGED_W-1:0]  age_days,
	input  logic [STAT_W-1:0]  status,
	output int                 mismatches,
	output int                 open_count
);

	typedef struct {
		logic [CNT_W-1:0]  count;
		logic [AGEY_W-1:0] years;
		logic [AGEM_W-1:0] months;
		logic [AGED_W-1:0] days;
		status_t           stat;
	} date_span_t;

	localparam int unsigned CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
		304, 334};

	date_span_t expected_spans[$];
	int         fail_total = 0;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic bit date_valid(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned days_in_month;
		if (y < 1 || y > MAX_YEAR || m < 1 || m > 12)
			return 1'b0;
		case (m)
			MONTH_FEB:       days_in_month = leap_year(y) ? 29 : 28;
			4, 6, 9, 11:     days_in_month = 30;
			default:         days_in_month = 31;
		endcase
		return d >= 1 && d <= days_in_month;
	endfunction

	function automatic int unsigned day_index(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned past;
		int unsigned n;
		past = y - 1;
		n = past * 365 + past / 4 - past / 100 + past / 400 + CUM_DAYS[m - 1] + d - 1;
		if (m > MONTH_FEB && leap_year(y))
			n++;
		return n;
	endfunction

	function automatic date_span_t span_of(input int unsigned sd, input int unsigned sm,
			input int unsigned sy, input int unsigned ed, input int unsigned em,
			input int unsigned ey);
		date_span_t  r;
		int unsigned first;
		int unsigned last;
		int unsigned n;
		r.count  = '0;
		r.years  = '0;
		r.months = '0;
		r.days   = '0;
		r.stat   = STATUS_OK;
		if (!date_valid(sd, sm, sy) || !date_valid(ed, em, ey)) begin
			r.stat = STATUS_INVALID;
		end else begin
			first = day_index(sd, sm, sy);
			last  = day_index(ed, em, ey);
			if (last < first) begin
				r.stat = STATUS_ORDER;
			end else begin
				n = last - first;
				if (n > COUNT_MAX)
					n = COUNT_MAX;
				r.count  = CNT_W'(n);
				r.years  = AGEY_W'(n / 365);
				r.months = AGEM_W'((n % 365) / 30);
				r.days   = AGED_W'((n % 365) % 30);
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		date_span_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_spans.push_back(span_of(start_day, start_month, start_year,
					end_day, end_month, end_year));
			if (out_valid && out_ready) begin
				if (expected_spans.size() == 0) begin
					$display("%0t: unexpected result day_count=%0d status=%0d", $time,
						day_count, status);
					fail_total++;
				end else begin
					want = expected_spans.pop_front();
					if (day_count !== want.count) begin
						$display("%0t: day_count expected %0d actual %0d", $time,
							want.count, day_count);
						fail_total++;
					end
					if (age_years !== want.years) begin
						$display("%0t: age_years expected %0d actual %0d", $time,
							want.years, age_years);
						fail_total++;
					end
					if (age_months !== want.months) begin
						$display("%0t: age_months expected %0d actual %0d", $time,
							want.months, age_months);
						fail_total++;
					end
					if (age_days !== want.days) begin
						$display("%0t: age_days expected %0d actual %0d", $time,
							want.days, age_days);
						fail_total++;
					end
					if (status !== want.stat) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.stat, status);
						fail_total++;
					end
				end
			end
		end
		mismatches <= fail_total;
		open_count <= expected_spans.size();
	end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the day counter: reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb;
	import gdbd_pkg::*;

	localparam int unsigned MAX_YEAR    = MAX_YEAR_DEF;
	localparam int          CYCLE_LIMIT = 300000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [DAY_W-1:0]   start_day   = '0;
	logic [MONTH_W-1:0] start_month = '0;
	logic [YEAR_W-1:0]  start_year  = '0;
	logic [DAY_W-1:0]   end_day     = '0;
	logic [MONTH_W-1:0] end_month   = '0;
	logic [YEAR_W-1:0]  end_year    = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [CNT_W-1:0]   day_count;
	logic [AGEY_W-1:0]  age_years;
	logic [AGEM_W-1:0]  age_months;
	logic [AGED_W-1:0]  age_days;
	logic [STAT_W-1:0]  status;

	int mismatches;
	int open_count;
	int n_sent     = 0;
	int burst_left = 0;
	int cycles     = 0;
	bit steady     = 1'b0;

	gregorian_days_between_dates_core #(.MAX_YEAR(MAX_YEAR)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_day(start_day), .start_month(start_month), .start_year(start_year),
		.end_day(end_day), .end_month(end_month), .end_year(end_year),
		.out_valid(out_valid), .out_ready(out_ready),
		.day_count(day_count), .age_years(age_years), .age_months(age_months),
		.age_days(age_days), .status(status)
	);

	day_span_checker #(.MAX_YEAR(MAX_YEAR)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_day(start_day), .start_month(start_month), .start_year(start_year),
		.end_day(end_day), .end_month(end_month), .end_year(end_year),
		.out_valid(out_valid), .out_ready(out_ready),
		.day_count(day_count), .age_years(age_years), .age_months(age_months),
		.age_days(age_days), .status(status),
		.mismatches(mismatches), .open_count(open_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_dates(input int unsigned sd, input int unsigned sm,
			input int unsigned sy, input int unsigned ed, input int unsigned em,
			input int unsigned ey);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		start_day   <= DAY_W'(sd);
		start_month <= MONTH_W'(sm);
		start_year  <= YEAR_W'(sy);
		end_day     <= DAY_W'(ed);
		end_month   <= MONTH_W'(em);
		end_year    <= YEAR_W'(ey);
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	function automatic int unsigned any_year();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(1, MAX_YEAR);
			1:       return $urandom_range(1, 50);
			2:       return $urandom_range(1, 99) * 100 - 1 + $urandom_range(0, 2);
			default: return $urandom_range(MAX_YEAR - 50, MAX_YEAR);
		endcase
	endfunction

	function automatic int unsigned any_day();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
	endfunction

	// receiver: stall patterns in segments, one long hold-off to back up the pipeline
	initial begin
		int unsigned mode;
		int unsigned seg;
		bit          held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			seg  = $urandom_range(20, 300);
			mode = $urandom_range(0, 3);
			repeat (seg) begin
				@(posedge clk);
				if (!held && n_sent >= 300) begin
					held = 1'b1;
					out_ready <= 1'b0;
					repeat (400) @(posedge clk);
				end else begin
					case (mode)
						0:       out_ready <= 1'b1;
						1:       out_ready <= $urandom_range(0, 1);
						2:       out_ready <= ($urandom_range(0, 7) != 0);
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin
		int unsigned sd, sm, sy, ed, em, ey;
		int unsigned kind;
		int unsigned t;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_dates(1, 1, 1, 1, 1, 1);
		send_dates(1, 1, 1, 31, 12, MAX_YEAR);
		send_dates(31, 12, MAX_YEAR, 1, 1, 1);
		send_dates(28, 2, 2000, 1, 3, 2000);
		send_dates(29, 2, 2000, 29, 2, 2004);
		send_dates(29, 2, 1900, 1, 3, 1900);
		send_dates(28, 2, 2001, 29, 2, 2001);
		send_dates(29, 2, 2400, 31, 12, 2400);
		send_dates(1, 1, 0, 1, 1, 5);
		send_dates(1, 1, 5, 1, 1, MAX_YEAR + 1);
		send_dates(1, 1, 16383, 1, 1, 16383);
		send_dates(1, 0, 10, 1, 1, 20);
		send_dates(1, 1, 10, 1, 13, 20);
		send_dates(1, 15, 10, 1, 15, 20);
		send_dates(0, 1, 10, 1, 1, 20);
		send_dates(31, 4, 10, 1, 5, 20);
		send_dates(31, 5, 10, 31, 5, 20);
		send_dates(31, 15, 16383, 31, 15, 16383);
		send_dates(2, 3, 1999, 1, 3, 1999);
		send_dates(15, 6, 1234, 15, 6, 1234);
		send_dates(1, 1, 10, 30, 2, 20);
		send_dates(31, 12, 1, 1, 1, 2);
		send_dates(1, 1, 1, 5, 1, 0);

		for (int i = 0; i < 1130; i++) begin
			steady = (i >= 500 && i < 700);
			kind = $urandom_range(0, 99);
			sy = any_year();
			sm = $urandom_range(1, 12);
			sd = any_day();
			if ($urandom_range(0, 1) != 0) begin
				ey = sy + $urandom_range(0, 3);
				if (ey > MAX_YEAR)
					ey = MAX_YEAR;
			end else begin
				ey = any_year();
			end
			em = $urandom_range(1, 12);
			ed = any_day();
			if (kind < 75) begin
				// order the pair, then reverse it for the end-before-start share
				if ({YEAR_W'(ey), MONTH_W'(em), DAY_W'(ed)} <
						{YEAR_W'(sy), MONTH_W'(sm), DAY_W'(sd)} ^ (kind >= 60)) begin
					t = sy; sy = ey; ey = t;
					t = sm; sm = em; em = t;
					t = sd; sd = ed; ed = t;
				end
			end else if (kind < 80) begin
				ed = sd;
				em = sm;
				ey = sy;
			end else if (kind < 90) begin
				case ($urandom_range(0, 5))
					0: sd = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(29, 31);
					1: sm = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 15);
					2: sy = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(MAX_YEAR + 1, 16383);
					3: ed = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(29, 31);
					4: em = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(13, 15);
					default: ey = ($urandom_range(0, 1) != 0) ? 0 :
						$urandom_range(MAX_YEAR + 1, 16383);
				endcase
			end else begin
				sd = $urandom() % 32;
				sm = $urandom() % 16;
				sy = $urandom() % 16384;
				ed = $urandom() % 32;
				em = $urandom() % 16;
				ey = $urandom() % 16384;
			end
			send_dates(sd, sm, sy, ed, em, ey);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gdbd_pkg.sv
rtl/gdbd_date.sv
rtl/gdbd_age.sv
rtl/gregorian_days_between_dates_core.sv
tb/sv/day_span_checker.sv
tb/sv/tb.sv
